### rtl/string_buffer_edit_search_core_defines.svh
// assertion macros for the string buffer edit and search core
`ifndef STRING_BUFFER_EDIT_SEARCH_CORE_DEFINES_SVH
`define STRING_BUFFER_EDIT_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define SBES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk_i, off during reset
`define SBES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SBES_ASSERT_NOW(lbl, ante, cons, msg)
`define SBES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/sbes_pkg.sv
// shared types and constants of the string buffer edit and search core
package sbes_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned LEN_OUT_W  = 5;
  localparam int unsigned PLEN_W     = 4;
  localparam int unsigned PAT_W      = 64;
  localparam int unsigned CFG_ADDR_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REVERSE = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_DELETE  = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_LAST,
    S_HOLD
  } state_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PATTERN = 1'b0,
    CFG_PLEN    = 1'b1
  } cfg_reg_e;

  // per-cell controls: rotate the byte ring, push the side stack, copy stack to ring
  typedef struct packed {
    logic shift;
    logic push;
    logic load;
  } cell_ctrl_t;

endpackage

### rtl/string_buffer_edit_search_core.sv
// top level of the string buffer edit and search core
// The buffer is a ring of CAPACITY byte cells. Every operation that touches the
// stored bytes (insert, reverse, search, delete, read) rotates the ring once
// round, one cell per cycle, which brings every byte past cell 0 in order and
// leaves the ring aligned again; edits happen by choosing what enters at the
// far end. Such an item passes through S_WALK, S_LAST and S_HOLD before the
// next accept; clear, unused codes and rejected inserts or reads go from the
// accept straight to S_HOLD. The search compares the pattern against the first
// cells of the ring in each step, so a match is found in the same pass; delete
// uses that same pass and refills from the cell one pattern length further on.
// Reverse pushes the bytes onto a side stack held in the cells and copies them
// back in S_LAST, after the walk. One item is worked on at a time; the next
// one is taken while the previous result still waits in the output register.
// Pattern lengths above PATTERN_MAX count as PATTERN_MAX.

`include "string_buffer_edit_search_core_defines.svh"

module string_buffer_edit_search_core #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned PATTERN_MAX = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [sbes_pkg::CFG_ADDR_W-1:0]  cfg_index_i,
  input  logic [sbes_pkg::PAT_W-1:0]       cfg_data_i,
  // input beats
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sbes_pkg::OP_W-1:0]        operation_i,
  input  logic [sbes_pkg::BYTE_W-1:0]      char_value_i,
  input  logic [sbes_pkg::POS_W-1:0]       position_i,
  // result beats
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sbes_pkg::STATUS_W-1:0]    status_o,
  output logic                             found_o,
  output logic [sbes_pkg::IDX_W-1:0]       match_index_o,
  output logic [sbes_pkg::LEN_OUT_W-1:0]   text_length_o,
  output logic [sbes_pkg::BYTE_W-1:0]      char_out_o
);
  import sbes_pkg::*;

  localparam int unsigned LEN_W  = $clog2(CAPACITY + 1);
  localparam int unsigned STEP_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
  localparam int unsigned TAP_N  = PATTERN_MAX + 1;
  localparam int unsigned TAP_IW = $clog2(TAP_N);

  // configuration
  logic [PAT_W-1:0]  pat_q;
  logic [PLEN_W-1:0] plen_cfg_q;
  logic [PLEN_W-1:0] plen;

  // control state
  state_e            state_q, state_d;
  logic [LEN_W-1:0]  len_q;
  logic [STEP_W-1:0] step_q;
  logic              hit_q;
  status_e           status_q;
  logic              out_valid_q;

  // per-item payload
  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] ch_q;
  logic [POS_W-1:0]  pos_q;
  logic [BYTE_W-1:0] carry_q;
  logic [BYTE_W-1:0] char_q;
  logic [STEP_W-1:0] at_q;

  // output register payload
  logic [STATUS_W-1:0]  status_out_q;
  logic                 found_out_q;
  logic [IDX_W-1:0]     idx_out_q;
  logic [LEN_OUT_W-1:0] len_out_q;
  logic [BYTE_W-1:0]    char_out_q;

  // ring
  logic [BYTE_W-1:0] main_w [CAPACITY];
  logic [BYTE_W-1:0] aux_w  [CAPACITY];
  cell_ctrl_t        ctrl_w [CAPACITY];
  logic [BYTE_W-1:0] tap    [TAP_N];
  logic [BYTE_W-1:0] feed;
  logic [BYTE_W-1:0] tap_sel;

  logic    accept;
  logic    start_walk;
  status_e start_status;
  logic    walking;
  logic    last_step;
  logic    win_ok;
  logic    match_all;
  logic    hit_now;
  logic    out_free;
  logic    push_en;
  logic    step_at_pos;

  // pattern length as used, saturated to the cells the search can see
  assign plen = (plen_cfg_q > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : plen_cfg_q;

  assign accept    = in_valid_i && !in_stall_o;
  assign walking   = (state_q == S_WALK);
  assign last_step = (step_q == STEP_W'(CAPACITY - 1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign step_at_pos = (CMP_W'(step_q) == CMP_W'(pos_q));

  // cell chain: each cell takes its right neighbor, the far end takes the feed;
  // the side stack grows from cell 0, which pushes the byte leaving the ring
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [BYTE_W-1:0] nxt_main;
    logic [BYTE_W-1:0] nxt_aux;

    if (k == CAPACITY - 1) begin : g_end
      assign nxt_main = feed;
    end else begin : g_mid
      assign nxt_main = main_w[k+1];
    end

    if (k == 0) begin : g_head
      assign nxt_aux = main_w[0];
    end else begin : g_body
      assign nxt_aux = aux_w[k-1];
    end

    assign ctrl_w[k].shift = walking;
    assign ctrl_w[k].push  = push_en;
    // copy back only the stored part; cells past the length keep their bytes
    assign ctrl_w[k].load  = (state_q == S_LAST) && (op_q == OP_REVERSE)
                             && (LEN_W'(k) < len_q);

    sbes_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_w[k]),
      .main_i (nxt_main),
      .aux_i  (nxt_aux),
      .main_o (main_w[k]),
      .aux_o  (aux_w[k])
    );
  end

  // fixed taps on the first cells for the pattern window and the delete refill
  for (genvar k = 0; k < TAP_N; k++) begin : g_tap
    if (k < CAPACITY) begin : g_real
      assign tap[k] = main_w[k];
    end else begin : g_none
      assign tap[k] = '0;
    end
  end

  assign tap_sel = tap[plen[TAP_IW-1:0]];

  // window of the pattern at the current offset lies inside the stored bytes
  assign win_ok = (CMP_W'(step_q) + CMP_W'(plen)) <= CMP_W'(len_q);

  always_comb begin
    match_all = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if ((PLEN_W'(j) < plen) && (tap[j] != pat_q[BYTE_W*j +: BYTE_W])) begin
        match_all = 1'b0;
      end
    end
  end

  assign hit_now = walking && ((op_q == OP_SEARCH) || (op_q == OP_DELETE))
                   && !hit_q && win_ok && match_all;

  // accept-time decode: reject or finish at once, or walk the ring
  always_comb begin
    start_walk   = 1'b0;
    start_status = ST_OK;
    unique case (operation_i) inside
      OP_INSERT: begin
        if (len_q >= LEN_W'(CAPACITY)) begin
          start_status = ST_FULL;
        end else if (CMP_W'(position_i) > CMP_W'(len_q)) begin
          start_status = ST_RANGE;
        end else begin
          start_walk = 1'b1;
        end
      end
      OP_REVERSE, OP_SEARCH, OP_DELETE: begin
        start_walk = 1'b1;
      end
      OP_READ: begin
        if (CMP_W'(position_i) >= CMP_W'(len_q)) begin
          start_status = ST_RANGE;
        end else begin
          start_walk = 1'b1;
        end
      end
      default: begin
        start_walk = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = start_walk ? S_WALK : S_HOLD;
        end
      end
      S_WALK: begin
        if (last_step) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state outputs: handshake, what enters the ring end, stack push
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    push_en    = walking && (op_q == OP_REVERSE) && (CMP_W'(step_q) < CMP_W'(len_q));
    feed       = main_w[0];
    if (walking) begin
      case (op_q)
        OP_INSERT: begin
          // before the position plain rotation, then the new byte, then the
          // tail through the carry register
          if (step_at_pos) begin
            feed = ch_q;
          end else if (CMP_W'(step_q) > CMP_W'(pos_q)) begin
            feed = carry_q;
          end
        end
        OP_DELETE: begin
          // from the match on, skip the matched bytes
          if (hit_now || hit_q) begin
            feed = tap_sel;
          end
        end
        default: begin
          feed = main_w[0];
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q      <= '0;
      plen_cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN: pat_q      <= cfg_data_i;
        CFG_PLEN:    plen_cfg_q <= cfg_data_i[PLEN_W-1:0];
        default:     pat_q      <= pat_q;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      step_q      <= '0;
      hit_q       <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (accept) begin
        step_q   <= '0;
        hit_q    <= 1'b0;
        status_q <= start_status;
        if (operation_i == OP_CLEAR) begin
          len_q <= '0;
        end
      end else if (walking) begin
        step_q <= step_q + STEP_W'(1);
        if (hit_now) begin
          hit_q <= 1'b1;
        end
      end

      // length changes once the pass is over
      if (state_q == S_LAST) begin
        if (op_q == OP_INSERT) begin
          len_q <= len_q + LEN_W'(1);
        end else if ((op_q == OP_DELETE) && hit_q) begin
          len_q <= len_q - LEN_W'(plen);
        end
      end

      if ((state_q == S_HOLD) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      ch_q   <= char_value_i;
      pos_q  <= position_i;
      char_q <= '0;
      at_q   <= '0;
    end else if (walking) begin
      carry_q <= main_w[0];
      if (hit_now) begin
        at_q <= step_q;
      end
      if ((op_q == OP_READ) && step_at_pos) begin
        char_q <= main_w[0];
      end
    end

    if ((state_q == S_HOLD) && out_free) begin
      status_out_q <= status_q;
      found_out_q  <= hit_q;
      idx_out_q    <= IDX_W'(at_q);
      len_out_q    <= LEN_OUT_W'(len_q);
      char_out_q   <= char_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_out_q;
  assign found_o       = found_out_q;
  assign match_index_o = idx_out_q;
  assign text_length_o = len_out_q;
  assign char_out_o    = char_out_q;

  // a match never reaches past the stored bytes
  `SBES_ASSERT_NOW(a_match_inside, hit_q && ((state_q == S_WALK) || (state_q == S_LAST)), (CMP_W'(at_q) + CMP_W'(plen)) <= CMP_W'(len_q), "match window past length")
  // found is only reported with ok status
  `SBES_ASSERT_NOW(a_found_ok, out_valid_o && found_o, status_o == ST_OK, "found with error status")
  // insert into a full buffer leaves the length alone
  `SBES_ASSERT_NEXT(a_full_keeps, accept && (operation_i == OP_INSERT) && (len_q == LEN_W'(CAPACITY)), $stable(len_q), "full insert changed length")

endmodule

### rtl/sbes_cell.sv
// one buffer cell: a ring byte and a side-stack byte used for reversal
module sbes_cell (
  input  logic                          clk_i,
  input  sbes_pkg::cell_ctrl_t          ctrl_i,
  input  logic [sbes_pkg::BYTE_W-1:0]   main_i,
  input  logic [sbes_pkg::BYTE_W-1:0]   aux_i,
  output logic [sbes_pkg::BYTE_W-1:0]   main_o,
  output logic [sbes_pkg::BYTE_W-1:0]   aux_o
);
  import sbes_pkg::*;

  logic [BYTE_W-1:0] main_q, main_d;
  logic [BYTE_W-1:0] aux_q, aux_d;

  always_comb begin
    main_d = main_q;
    if (ctrl_i.load) begin
      main_d = aux_q;
    end else if (ctrl_i.shift) begin
      main_d = main_i;
    end
    aux_d = ctrl_i.push ? aux_i : aux_q;
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    aux_q  <= aux_d;
  end

  assign main_o = main_q;
  assign aux_o  = aux_q;

endmodule

### sim/tb.sv
// self-checking testbench of the string buffer edit and search core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbes_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned PATTERN_MAX = 8;

  // operation codes the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  // beats of pattern traffic per register setting in the random part
  localparam int unsigned BEATS_PER_SETTING = 64;
  localparam int unsigned SETTINGS_PER_PHASE = 6;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [IDX_W-1:0]     match_index;
    logic [LEN_OUT_W-1:0] text_length;
    logic [BYTE_W-1:0]    char_out;
  } edit_result_t;

  // dut ports, the inputs all known from time zero
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index_i  = '0;
  logic [PAT_W-1:0]      cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       operation_i  = '0;
  logic [BYTE_W-1:0]     char_value_i = '0;
  logic [POS_W-1:0]      position_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic                  found_o;
  logic [IDX_W-1:0]      match_index_o;
  logic [LEN_OUT_W-1:0]  text_length_o;
  logic [BYTE_W-1:0]     char_out_o;

  // shadow copy of the buffer and the pattern registers
  logic [BYTE_W-1:0] text_shadow [CAPACITY];
  int unsigned       length_shadow;
  logic [PAT_W-1:0]  pattern_shadow;
  logic [PLEN_W-1:0] plen_shadow;

  edit_result_t pending_results [$];

  int unsigned error_count   = 0;
  int unsigned beats_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned reg_writes    = 0;
  int unsigned setting_round = 0;

  // idle rates in percent, and a long receiver hold-off counted down below
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned sink_hold_left = 0;

  string_buffer_edit_search_core #(
    .CAPACITY    (CAPACITY),
    .PATTERN_MAX (PATTERN_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .char_value_i  (char_value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .match_index_o (match_index_o),
    .text_length_o (text_length_o),
    .char_out_o    (char_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // lengths above the maximum count as the maximum
  function automatic int unsigned active_plen();
    return (plen_shadow > PATTERN_MAX) ? PATTERN_MAX : int'(plen_shadow);
  endfunction

  // naive scan, offsets in rising order; an empty pattern hits at 0
  function automatic logic locate_pattern(output int unsigned at);
    int unsigned plen;
    logic        hit;
    plen = active_plen();
    at   = 0;
    if (plen > length_shadow) return 1'b0;
    for (int unsigned i = 0; i + plen <= length_shadow; i++) begin
      hit = 1'b1;
      for (int unsigned j = 0; j < plen; j++) begin
        if (text_shadow[i+j] != pattern_shadow[8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        at = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // applies one operation to the shadow buffer and returns the result it causes
  function automatic edit_result_t apply_edit(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch,
                                              logic [POS_W-1:0] pos);
    edit_result_t     res;
    int unsigned      at;
    int unsigned      plen;
    logic [BYTE_W-1:0] swap;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_CLEAR: begin
        length_shadow = 0;
      end
      OP_INSERT: begin
        // full is checked before the position
        if (length_shadow >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (pos > length_shadow) begin
          res.status = ST_RANGE;
        end else begin
          for (int unsigned i = length_shadow; i > pos; i--) text_shadow[i] = text_shadow[i-1];
          text_shadow[pos] = ch;
          length_shadow++;
        end
      end
      OP_REVERSE: begin
        for (int unsigned i = 0; i < length_shadow / 2; i++) begin
          swap = text_shadow[i];
          text_shadow[i] = text_shadow[length_shadow-1-i];
          text_shadow[length_shadow-1-i] = swap;
        end
      end
      OP_SEARCH: begin
        if (locate_pattern(at)) begin
          res.found       = 1'b1;
          res.match_index = at[IDX_W-1:0];
        end
      end
      OP_DELETE: begin
        if (locate_pattern(at)) begin
          plen = active_plen();
          res.found       = 1'b1;
          res.match_index = at[IDX_W-1:0];
          for (int unsigned i = at; i + plen < length_shadow; i++) begin
            text_shadow[i] = text_shadow[i+plen];
          end
          length_shadow -= plen;
        end
      end
      OP_READ: begin
        if (pos >= length_shadow) res.status = ST_RANGE;
        else res.char_out = text_shadow[pos];
      end
      default: begin
      end
    endcase
    res.text_length = length_shadow[LEN_OUT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------

  // a pending hold-off wins over the random stall rate
  always @(negedge clk_i) begin
    if (sink_hold_left > 0) begin
      out_stall_i <= 1'b1;
      sink_hold_left = sink_hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    edit_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual status %0d length %0d",
                 $time, status_o, text_length_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("found", want.found, found_o);
        check_field("match_index", want.match_index, match_index_o);
        check_field("text_length", want.text_length, text_length_o);
        check_field("char_out", want.char_out, char_out_o);
        beats_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offers one beat after a random gap and books its result once accepted;
  // valid stays high after the accept until the next call decides otherwise
  task automatic send_beat(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch, logic [POS_W-1:0] pos);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    char_value_i <= ch;
    position_i   <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_edit(op, ch, pos));
    beats_sent++;
  endtask

  // sender pauses until every booked result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [PAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == CFG_PATTERN) pattern_shadow = data;
    else plen_shadow = data[PLEN_W-1:0];
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // registers only change while the block is idle; upper bits of the
  // length write carry noise
  task automatic load_pattern(logic [PAT_W-1:0] chars, logic [PLEN_W-1:0] plen);
    logic [PAT_W-1:0] plen_word;
    drain_results();
    plen_word = {$urandom, $urandom};
    plen_word[PLEN_W-1:0] = plen;
    write_reg(CFG_PATTERN, chars);
    write_reg(CFG_PLEN, plen_word);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty buffer: empty pattern hits, reads and inserts out of range,
  // unused codes, pattern longer than the stored text
  task automatic test_empty_buffer();
    send_beat(OP_SEARCH, 8'h00, 5'd0);
    send_beat(OP_DELETE, 8'h00, 5'd0);
    send_beat(OP_READ, 8'h00, 5'd0);
    send_beat(OP_INSERT, 8'h41, 5'd1);
    send_beat(OP_UNUSED_6, 8'hFF, 5'd31);
    send_beat(OP_UNUSED_7, 8'h00, 5'd0);
    load_pattern(64'hA5A5_A5A5_A5A5_00FF, 4'd8);
    send_beat(OP_SEARCH, 8'h00, 5'd0);
  endtask

  // fill to capacity at front, back and middle, then one insert too many
  task automatic test_fill_and_overflow();
    logic [POS_W-1:0] pos;
    load_pattern(64'hA5A5_A5A5_A5A5_00FF, 4'd2);
    for (int unsigned i = 0; i < CAPACITY - 2; i++) begin
      case (i % 3)
        0:       pos = '0;
        1:       pos = POS_W'(length_shadow);
        default: pos = POS_W'(length_shadow / 2);
      endcase
      send_beat(OP_INSERT, 8'(i * 37 + 1), pos);
    end
    // pattern bytes end up at the tail: ff then 00
    send_beat(OP_INSERT, 8'h00, POS_W'(length_shadow));
    send_beat(OP_INSERT, 8'hFF, POS_W'(length_shadow - 1));
    // full wins over the bad position
    send_beat(OP_INSERT, 8'h5A, 5'd31);
  endtask

  task automatic test_edit_ops();
    send_beat(OP_SEARCH, 8'h00, 5'd0);
    send_beat(OP_REVERSE, 8'h00, 5'd0);
    send_beat(OP_SEARCH, 8'h00, 5'd0);
    send_beat(OP_REVERSE, 8'h00, 5'd0);
    send_beat(OP_DELETE, 8'h00, 5'd0);
    send_beat(OP_READ, 8'h00, 5'd0);
    send_beat(OP_READ, 8'h00, POS_W'(length_shadow));
    // length beyond the maximum saturates
    load_pattern(64'h0706_0504_0302_0100, 4'd15);
    send_beat(OP_SEARCH, 8'h00, 5'd0);
  endtask

  // receiver holds off long enough that the block fills and stalls its input
  task automatic test_backpressure();
    drain_results();
    sink_hold_left = 300;
    for (int unsigned i = 0; i < 12; i++) begin
      send_beat(OP_INSERT, 8'($urandom), POS_W'($urandom_range(length_shadow)));
    end
    drain_results();
  endtask

  // well-formed editing traffic built from the pattern bytes, plus noise
  task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct);
    int unsigned       plen_pick [9] = '{1, 0, 2, 8, 3, 15, 4, 9, 5};
    logic [PAT_W-1:0]  chars;
    int unsigned       feed;
    int unsigned       roll;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int unsigned s = 0; s < SETTINGS_PER_PHASE; s++) begin
      chars = {$urandom, $urandom};
      if (setting_round % 9 == 2) chars = '1;
      if (setting_round % 9 == 5) chars = '0;
      load_pattern(chars, PLEN_W'(plen_pick[setting_round % 9]));
      setting_round++;
      feed = 0;
      for (int unsigned n = 0; n < BEATS_PER_SETTING; n++) begin
        roll = $urandom_range(99);
        ch   = 8'($urandom);
        pos  = POS_W'($urandom);
        if (roll < 45) begin
          op = OP_INSERT;
          // mostly append the next pattern byte so matches build up
          if (active_plen() > 0 && $urandom_range(99) < 60) begin
            ch   = pattern_shadow[8*(feed % active_plen()) +: 8];
            feed = feed + 1;
          end
          roll = $urandom_range(99);
          if (roll < 70) pos = POS_W'(length_shadow);
          else if (roll < 90) pos = POS_W'($urandom_range(length_shadow));
        end else if (roll < 57) begin
          op = OP_SEARCH;
        end else if (roll < 67) begin
          op = OP_DELETE;
        end else if (roll < 74) begin
          op = OP_REVERSE;
        end else if (roll < 88) begin
          op = OP_READ;
          if (length_shadow > 0 && $urandom_range(99) < 85) begin
            pos = POS_W'($urandom_range(length_shadow - 1));
          end
        end else if (roll < 93) begin
          op   = OP_CLEAR;
          feed = 0;
        end else if (roll < 96) begin
          op = $urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6;
        end else begin
          op = OP_W'($urandom);
        end
        send_beat(op, ch, pos);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int unsigned i = 0; i < CAPACITY; i++) text_shadow[i] = '0;
    length_shadow  = 0;
    pattern_shadow = '0;
    plen_shadow    = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender idles a quarter of the time, receiver two thirds
    src_idle_pct  = 25;
    sink_idle_pct = 67;
    test_empty_buffer();
    test_fill_and_overflow();
    test_edit_ops();
    test_random_traffic(25, 67);
    test_random_traffic(67, 25);
    test_random_traffic(0, 0);
    test_backpressure();

    drain_results();
    repeat (2 * (CAPACITY + 3)) @(posedge clk_i);
    $display("run: %0d beats sent, %0d results checked, %0d register writes",
             beats_sent, beats_checked, reg_writes);
    $display("run: empty and full buffer, all opcodes, pattern lengths 0 to 15, long hold-off");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
